// ===== sv/lcx_pkg.sv =====
`default_nettype none

package lcx_pkg;

    localparam int ENTRIES       = 16;
    localparam int IDX_BITS      = $clog2(ENTRIES);
    localparam int CNT_BITS      = $clog2(ENTRIES + 1);
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int TIME_BITS     = 32;
    localparam int LIMIT_BITS    = 5;
    localparam int TTL_BITS      = 31;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);
    localparam logic [TTL_BITS-1:0]   TTL_RESET   = TTL_BITS'(300000);

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TTL_TICKS      = 1'b1;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_STORE  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_INSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic apply;
        logic evict;
        logic insert;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic found;
        logic need_evict;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/lru_cache_with_expiry.sv =====
// channel   handshake          payload
// request   start & !busy      operation, key, store_value
// result    done (one cycle)   hit, read_value, was_present, expired_dropped,
//                              evicted, occupancy
// config    cfg_we             cfg_index, cfg_data
//
// a transaction runs through the match, apply and done states before the next
// accept; a store of a new key adds the free slot insert after the eviction step
// the result is shown for one cycle, in the done state
// reset clears valid bits, ranks, count and time at once; no clearing pass
// the receiver cannot stall; busy stays high until the result cycle has ended
`default_nettype none

module lru_cache_with_expiry
    import lcx_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               operation,
    input  wire logic [KEY_BITS-1:0]      key,
    input  wire logic [VALUE_BITS-1:0]    store_value,
    output logic                          done,
    output logic                          hit,
    output logic [VALUE_BITS-1:0]         read_value,
    output logic                          was_present,
    output logic                          expired_dropped,
    output logic                          evicted,
    output logic [CNT_BITS-1:0]           occupancy,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lcx_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    lcx_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .key             (key),
        .store_value     (store_value),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .hit             (hit),
        .read_value      (read_value),
        .was_present     (was_present),
        .expired_dropped (expired_dropped),
        .evicted         (evicted),
        .occupancy       (occupancy)
    );

endmodule

`default_nettype wire

// ===== sv/lcx_ctrl.sv =====
`default_nettype none

module lcx_ctrl
    import lcx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output logic            busy,
    output logic            done,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (status.op == OP_STORE && !status.found)
                begin
                    cmd.evict  = status.need_evict;
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/lcx_datapath.sv =====
`default_nettype none

module lcx_datapath
    import lcx_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    output dp_status_t                    status,
    input  wire logic [2:0]               operation,
    input  wire logic [KEY_BITS-1:0]      key,
    input  wire logic [VALUE_BITS-1:0]    store_value,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                          hit,
    output logic [VALUE_BITS-1:0]         read_value,
    output logic                          was_present,
    output logic                          expired_dropped,
    output logic                          evicted,
    output logic [CNT_BITS-1:0]           occupancy
);

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [TIME_BITS-1:0]  birth_mem [ENTRIES];

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [IDX_BITS-1:0]   rank_reg  [ENTRIES];
    logic [IDX_BITS-1:0]   rank_next [ENTRIES];
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [TIME_BITS-1:0]  time_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [TTL_BITS-1:0]   ttl_reg;

    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS-1:0]   victim_reg;
    logic                  need_evict_reg;
    logic [TIME_BITS-1:0]  birth_reg;

    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    logic                  present_reg;
    logic                  expd_reg;
    logic                  evic_reg;

    logic                  match_any;
    logic [IDX_BITS-1:0]   match_idx;
    logic [IDX_BITS-1:0]   victim_idx;
    logic [IDX_BITS-1:0]   last_rank;
    logic [CNT_BITS-1:0]   limit_eff;
    logic                  free_any;
    logic [IDX_BITS-1:0]   free_idx;
    logic [TIME_BITS-1:0]  age;
    logic                  expired;

    // key match, victim and free slot search
    always_comb
    begin
        match_any  = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        free_any   = 1'b0;
        free_idx   = '0;
        last_rank  = IDX_BITS'(count_reg - CNT_BITS'(1));
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_mem[i] == key_reg)
            begin
                match_any = 1'b1;
                match_idx = IDX_BITS'(i);
            end
            if (valid_reg[i] && rank_reg[i] == last_rank)
            begin
                victim_idx = IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = CNT_BITS'(1);
        end
        else if (CNT_BITS'(limit_reg) > CNT_BITS'(ENTRIES))
        begin
            limit_eff = CNT_BITS'(ENTRIES);
        end
        else
        begin
            limit_eff = CNT_BITS'(limit_reg);
        end
    end

    assign age     = time_reg - birth_reg;
    assign expired = age > TIME_BITS'(ttl_reg);

    // valid, rank and count update
    always_comb
    begin
        logic [IDX_BITS-1:0] r;
        logic                do_drop;
        logic                do_promote;
        logic [IDX_BITS-1:0] slot;

        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        do_drop    = 1'b0;
        do_promote = 1'b0;
        slot       = idx_reg;

        if (cmd.apply && found_reg)
        begin
            case (op_reg)
                OP_LOOKUP:
                begin
                    do_drop    = expired;
                    do_promote = !expired;
                end
                OP_STORE:
                begin
                    do_promote = 1'b1;
                end
                OP_REMOVE:
                begin
                    do_drop = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.evict)
        begin
            do_drop = 1'b1;
            slot    = victim_reg;
        end
        r = rank_reg[slot];

        if (do_promote)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && rank_reg[i] < r)
                begin
                    rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
            end
            rank_next[slot] = '0;
        end

        if (do_drop)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && rank_reg[i] > r)
                begin
                    rank_next[i] = rank_reg[i] - IDX_BITS'(1);
                end
            end
            valid_next[slot] = 1'b0;
            rank_next[slot]  = '0;
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_BITS'(1);
            end
        end

        if (cmd.apply && op_reg == OP_CLEAR)
        begin
            valid_next = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_next[i] = '0;
            end
            count_next = '0;
        end

        if (cmd.insert && free_any)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
            end
            valid_next[free_idx] = 1'b1;
            rank_next[free_idx]  = '0;
            count_next           = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
            count_reg   <= '0;
            time_reg    <= '0;
            limit_reg   <= LIMIT_RESET;
            ttl_reg     <= TTL_RESET;
            found_reg   <= 1'b0;
            need_evict_reg <= 1'b0;
            op_reg      <= OP_LOOKUP;
            hit_reg     <= 1'b0;
            present_reg <= 1'b0;
            expd_reg    <= 1'b0;
            evic_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY_LIMIT: limit_reg <= cfg_data[LIMIT_BITS-1:0];
                    CFG_TTL_TICKS:      ttl_reg   <= cfg_data[TTL_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.load)
            begin
                op_reg      <= op_t'(operation);
                hit_reg     <= 1'b0;
                present_reg <= 1'b0;
                expd_reg    <= 1'b0;
                evic_reg    <= 1'b0;
            end

            if (cmd.match)
            begin
                found_reg      <= match_any;
                need_evict_reg <= count_reg >= limit_eff;
                if (op_reg == OP_LOOKUP || op_reg == OP_STORE || op_reg == OP_REMOVE)
                begin
                    present_reg <= match_any;
                end
            end

            if (cmd.apply)
            begin
                if (op_reg == OP_LOOKUP && found_reg)
                begin
                    hit_reg  <= !expired;
                    expd_reg <= expired;
                end
                if (op_reg == OP_TICK)
                begin
                    time_reg <= time_reg + TIME_BITS'(1);
                end
            end

            if (cmd.evict)
            begin
                evic_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key[KEY_BITS-1:0];
            val_reg <= store_value[VALUE_BITS-1:0];
            rv_reg  <= '0;
        end
        if (cmd.match)
        begin
            idx_reg    <= match_idx;
            victim_reg <= victim_idx;
            birth_reg  <= birth_mem[match_idx];
        end
        if (cmd.apply && found_reg)
        begin
            if (op_reg == OP_LOOKUP && !expired)
            begin
                rv_reg <= value_mem[idx_reg];
            end
            if (op_reg == OP_STORE)
            begin
                value_mem[idx_reg] <= val_reg;
            end
        end
        if (cmd.insert && free_any)
        begin
            key_mem[free_idx]   <= key_reg;
            value_mem[free_idx] <= val_reg;
            birth_mem[free_idx] <= time_reg;
        end
    end

    assign status.op         = op_reg;
    assign status.found      = found_reg;
    assign status.need_evict = need_evict_reg;

    assign hit             = hit_reg;
    assign read_value      = rv_reg;
    assign was_present     = present_reg;
    assign expired_dropped = expd_reg;
    assign evicted         = evic_reg;
    assign occupancy       = count_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import lcx_pkg::*;
();

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int PHASES    = 8;
    localparam int PHASE_OPS = 60;
    localparam int KEY_POOL  = 24;
    localparam int PAD_BITS  = CFG_DATA_BITS - LIMIT_BITS;

    typedef enum logic [1:0] {
        STEP_OP,
        STEP_CFG,
        STEP_IDLE
    } step_kind_t;

    typedef struct {
        step_kind_t               kind;
        logic [2:0]               op;
        logic [KEY_BITS-1:0]      k;
        logic [VALUE_BITS-1:0]    v;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_data;
        int                       cycles;
    } script_step_t;

    typedef struct {
        logic                  hit;
        logic [VALUE_BITS-1:0] rd;
        logic                  present;
        logic                  dropped;
        logic                  evict;
        logic [CNT_BITS-1:0]   occ;
    } cache_answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               operation = '0;
    logic [KEY_BITS-1:0]      key = '0;
    logic [VALUE_BITS-1:0]    store_value = '0;
    logic                     done;
    logic                     hit;
    logic [VALUE_BITS-1:0]    read_value;
    logic                     was_present;
    logic                     expired_dropped;
    logic                     evicted;
    logic [CNT_BITS-1:0]      occupancy;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    lru_cache_with_expiry i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .key             (key),
        .store_value     (store_value),
        .done            (done),
        .hit             (hit),
        .read_value      (read_value),
        .was_present     (was_present),
        .expired_dropped (expired_dropped),
        .evicted         (evicted),
        .occupancy       (occupancy),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // shadow copy of the cache contents
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_val   [ENTRIES];
    logic [TIME_BITS-1:0]  slot_born  [ENTRIES];
    bit                    slot_used  [ENTRIES];
    int unsigned           slot_rank  [ENTRIES];
    logic [TIME_BITS-1:0]  now_ticks  = '0;
    int unsigned           used_count = 0;
    logic [LIMIT_BITS-1:0] limit_reg  = LIMIT_RESET;
    logic [TTL_BITS-1:0]   ttl_reg    = TTL_RESET;

    script_step_t  op_script[$];
    cache_answer_t cache_answers[$];
    int            hold_cycles = 0;
    int            n_errors = 0;
    logic [KEY_BITS-1:0] key_pool [KEY_POOL];

    logic [LIMIT_BITS-1:0] phase_limit [PHASES] =
        '{5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd1, 5'd12, 5'd16};
    logic [CFG_DATA_BITS-1:0] phase_ttl [PHASES] =
        '{31'h7FFF_FFFF, 31'd40, 31'd0, 31'd6, 31'd15, 31'd300000, 31'd2, 31'd25};

    function automatic int find_key(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void make_newest(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void drop_slot(int s);
        int unsigned r;
        r = slot_rank[s];
        slot_used[s] = 1'b0;
        slot_rank[s] = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_rank[i] > r)
                slot_rank[i]--;
        if (used_count > 0)
            used_count--;
    endfunction

    function automatic cache_answer_t run_cache_op(logic [2:0] op, logic [KEY_BITS-1:0] k,
                                                   logic [VALUE_BITS-1:0] v);
        cache_answer_t        a;
        int                   s;
        int                   victim;
        int unsigned          lim;
        logic [TIME_BITS-1:0] age;
        a.hit = 1'b0;
        a.rd = '0;
        a.present = 1'b0;
        a.dropped = 1'b0;
        a.evict = 1'b0;
        case (op)
            OP_LOOKUP:
            begin
                s = find_key(k);
                if (s >= 0)
                begin
                    a.present = 1'b1;
                    age = now_ticks - slot_born[s];
                    if (age > TIME_BITS'(ttl_reg))
                    begin
                        drop_slot(s);
                        a.dropped = 1'b1;
                    end
                    else
                    begin
                        make_newest(s);
                        a.hit = 1'b1;
                        a.rd = slot_val[s];
                    end
                end
            end
            OP_STORE:
            begin
                s = find_key(k);
                if (s >= 0)
                begin
                    a.present = 1'b1;
                    slot_val[s] = v;
                    make_newest(s);
                end
                else
                begin
                    lim = limit_reg;
                    if (lim < 1)
                        lim = 1;
                    if (lim > ENTRIES)
                        lim = ENTRIES;
                    if (used_count >= lim)
                    begin
                        victim = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i] &&
                                (victim < 0 || slot_rank[i] > slot_rank[victim]))
                                victim = i;
                        if (victim >= 0)
                        begin
                            drop_slot(victim);
                            a.evict = 1'b1;
                        end
                    end
                    s = -1;
                    for (int i = 0; i < ENTRIES && s < 0; i++)
                        if (!slot_used[i])
                            s = i;
                    if (s >= 0)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i])
                                slot_rank[i]++;
                        slot_used[s] = 1'b1;
                        slot_key[s] = k;
                        slot_val[s] = v;
                        slot_born[s] = now_ticks;
                        slot_rank[s] = 0;
                        used_count++;
                    end
                end
            end
            OP_REMOVE:
            begin
                s = find_key(k);
                if (s >= 0)
                begin
                    a.present = 1'b1;
                    drop_slot(s);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    slot_used[i] = 1'b0;
                    slot_rank[i] = 0;
                end
                used_count = 0;
            end
            OP_TICK:
                now_ticks = now_ticks + 1'b1;
            default:
                ;
        endcase
        a.occ = CNT_BITS'(used_count);
        return a;
    endfunction

    function automatic void queue_op(logic [2:0] op, logic [KEY_BITS-1:0] k,
                                     logic [VALUE_BITS-1:0] v);
        script_step_t st;
        st.kind = STEP_OP;
        st.op = op;
        st.k = k;
        st.v = v;
        st.reg_idx = '0;
        st.reg_data = '0;
        st.cycles = 0;
        op_script.insert(op_script.size(), st);
    endfunction

    function automatic void queue_cfg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        script_step_t st;
        st.kind = STEP_CFG;
        st.op = OP_LOOKUP;
        st.k = '0;
        st.v = '0;
        st.reg_idx = idx;
        st.reg_data = data;
        st.cycles = 0;
        op_script.insert(op_script.size(), st);
    endfunction

    function automatic void queue_idle(int n);
        script_step_t st;
        st.kind = STEP_IDLE;
        st.op = OP_LOOKUP;
        st.k = '0;
        st.v = '0;
        st.reg_idx = '0;
        st.reg_data = '0;
        st.cycles = n;
        op_script.insert(op_script.size(), st);
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("[%0t] mismatch:%s", $time, what);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_600_000;
        $display("FAILED: results differ");
        $finish;
    end

    // driver: one transaction in flight at a time, config only when idle
    always @(posedge clk or negedge rst_n)
    begin : drive
        script_step_t nxt;
        logic taken;
        logic go;
        logic wr;
        if (!rst_n)
        begin
            start <= 1'b0;
            operation <= '0;
            key <= '0;
            store_value <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            taken = start && !busy;
            go = start && !taken;
            wr = 1'b0;
            if (taken)
                cache_answers.insert(cache_answers.size(),
                                     run_cache_op(operation, key, store_value));
            if (!go)
            begin
                if (hold_cycles > 0)
                    hold_cycles--;
                else if (op_script.size() != 0)
                begin
                    nxt = op_script[0];
                    case (nxt.kind)
                        STEP_IDLE:
                        begin
                            hold_cycles = nxt.cycles - 1;
                            op_script.delete(0);
                        end
                        STEP_CFG:
                        begin
                            if (!start && !busy && cache_answers.size() == 0)
                            begin
                                wr = 1'b1;
                                cfg_index <= nxt.reg_idx;
                                cfg_data <= nxt.reg_data;
                                if (nxt.reg_idx == CFG_CAPACITY_LIMIT)
                                    limit_reg = nxt.reg_data[LIMIT_BITS-1:0];
                                else if (nxt.reg_idx == CFG_TTL_TICKS)
                                    ttl_reg = nxt.reg_data[TTL_BITS-1:0];
                                op_script.delete(0);
                            end
                        end
                        default:
                        begin
                            go = 1'b1;
                            operation <= nxt.op;
                            key <= nxt.k;
                            store_value <= nxt.v;
                            op_script.delete(0);
                        end
                    endcase
                end
            end
            start <= go;
            cfg_we <= wr;
        end
    end

    // monitor: every done strobe is one transaction result
    always @(posedge clk)
    begin : watch
        cache_answer_t want;
        string diffs;
        if (rst_n && done)
        begin
            if (cache_answers.size() == 0)
                report_mismatch(" result with no transaction outstanding");
            else
            begin
                want = cache_answers[0];
                cache_answers.delete(0);
                diffs = "";
                if (hit !== want.hit)
                    diffs = {diffs, $sformatf(" hit=%0b/%0b", hit, want.hit)};
                if (read_value !== want.rd)
                    diffs = {diffs, $sformatf(" read_value=%h/%h", read_value, want.rd)};
                if (was_present !== want.present)
                    diffs = {diffs, $sformatf(" was_present=%0b/%0b", was_present,
                                              want.present)};
                if (expired_dropped !== want.dropped)
                    diffs = {diffs, $sformatf(" expired_dropped=%0b/%0b", expired_dropped,
                                              want.dropped)};
                if (evicted !== want.evict)
                    diffs = {diffs, $sformatf(" evicted=%0b/%0b", evicted, want.evict)};
                if (occupancy !== want.occ)
                    diffs = {diffs, $sformatf(" occupancy=%0d/%0d", occupancy, want.occ)};
                if (diffs != "")
                    report_mismatch({diffs, " (got/want)"});
            end
        end
    end

    initial
    begin : stimulus
        int         r;
        logic [2:0] op;
        logic [KEY_BITS-1:0] k;
        bit         calm;

        calm = 1'b0;

        // directed: two entries, ttl of one tick
        queue_cfg(CFG_CAPACITY_LIMIT, 31'd2);
        queue_cfg(CFG_TTL_TICKS, 31'd1);
        queue_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_STORE, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_STORE, 32'h1234_5678, 32'hA5A5_A5A5);
        queue_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_STORE, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        queue_op(OP_REMOVE, 32'hDEAD_BEEF, 32'h0000_0000);
        queue_op(OP_REMOVE, 32'h1234_5678, 32'h0000_0000);
        queue_op(OP_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // store to an entry that has aged out
        queue_op(OP_STORE, 32'h0000_0011, 32'h0000_0001);
        queue_op(OP_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_TICK, 32'h0000_0000, 32'h0000_0000);
        queue_op(OP_STORE, 32'h0000_0011, 32'h0000_0002);
        queue_op(OP_LOOKUP, 32'h0000_0011, 32'h0000_0000);
        queue_op(OP_SPARE_5, $urandom, $urandom);
        queue_op(OP_SPARE_6, $urandom, $urandom);
        queue_op(OP_SPARE_7, $urandom, $urandom);
        queue_op(OP_STORE, 32'h0000_0022, 32'h0000_0033);
        queue_op(OP_CLEAR, 32'h0000_0022, 32'h0000_0000);
        queue_op(OP_LOOKUP, 32'h0000_0022, 32'h0000_0000);
        // limit of zero behaves as one; upper data bits are don't care
        queue_cfg(CFG_CAPACITY_LIMIT, 31'h7FFF_FFE0);
        queue_op(OP_STORE, 32'h0000_0001, 32'h0000_0001);
        queue_op(OP_STORE, 32'h0000_0002, 32'h0000_0002);
        queue_op(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            queue_cfg(CFG_CAPACITY_LIMIT, {PAD_BITS'($urandom), phase_limit[p]});
            queue_cfg(CFG_TTL_TICKS, phase_ttl[p]);
            for (int j = 0; j < KEY_POOL; j++)
                key_pool[j] = $urandom;
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                if ($urandom_range(15) == 0)
                    calm = !calm;
                if (p < PHASES - 1 && !calm && $urandom_range(2) == 0)
                    queue_idle($urandom_range(1, 18));
                r = $urandom_range(99);
                if (r < 34)
                    op = OP_LOOKUP;
                else if (r < 68)
                    op = OP_STORE;
                else if (r < 77)
                    op = OP_REMOVE;
                else if (r < 94)
                    op = OP_TICK;
                else if (r < 96)
                    op = OP_CLEAR;
                else
                    op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
                if ($urandom_range(9) == 0)
                    k = KEY_BITS'($urandom);
                else
                    k = key_pool[$urandom_range(KEY_POOL - 1)];
                queue_op(op, k, $urandom);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_script.size() != 0 || start || cache_answers.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);

        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lcx_pkg.sv
sv/lcx_ctrl.sv
sv/lcx_datapath.sv
sv/lru_cache_with_expiry.sv
sim/tb_top.sv
